// ===== rtl/dtn_pkg.sv =====
// ----------------------------------------------------------------------------
// dtn_pkg: shared types, constants and calendar tables
// Widths, divisor and reciprocal constants, the month-start table and the
// leap rule used by the date and time normalizer and its divider.
// ----------------------------------------------------------------------------
package dtn_pkg;

  localparam int DivW   = 41;
  localparam int DsrW   = 26;
  localparam int QuoW   = 16;
  localparam int QW     = QuoW + 2;
  localparam int YearW  = 17;
  localparam int YdayW  = 20;
  localparam int HourW  = 19;
  localparam int MinW   = 22;
  localparam int MicroShift = 8;

  localparam logic [DsrW-1:0] MicrosPerMin = DsrW'(60000000);
  localparam logic [DsrW-1:0] MinPerHour   = DsrW'(60);
  localparam logic [DsrW-1:0] HourPerDay   = DsrW'(24);
  localparam logic [DsrW-1:0] MonPerYear   = DsrW'(12);
  localparam logic [DsrW-1:0] LeapCycle    = DsrW'(400);
  localparam logic [DsrW-1:0] MicrosRed    = DsrW'(234375);
  localparam logic [YearW-1:0] CenturyBase = YearW'(1900);

  localparam logic [31:0] RecipMicros = 32'd18325;
  localparam logic [31:0] RecipMin    = 32'd71582788;
  localparam logic [31:0] RecipHour   = 32'd178956970;
  localparam logic [31:0] RecipMon    = 32'd357913941;
  localparam logic [31:0] RecipCycle  = 32'd10737418;

  typedef struct packed {
    logic                   done;
    logic signed [QW-1:0]   quo;
    logic [DsrW-1:0]        rem;
  } div_res_t;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] v;
    case (mon)
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      4'd13:   v = 9'd365;
      default: v = 9'd0;
    endcase
    if (leap && mon > 4'd2) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

  function automatic logic leap_of(input logic [8:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

endpackage

// ===== rtl/dtn_div.sv =====
// ----------------------------------------------------------------------------
// dtn_div: shared floor divider
// Divides a signed value by one of the constant divisors through a shared
// reciprocal multiplier in a reciprocal step and a back-multiply step, with one
// correction step and a floor correction for negative dividends.
// ----------------------------------------------------------------------------
module dtn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [dtn_pkg::DivW-1:0] dividend,
  input  logic [dtn_pkg::DsrW-1:0]      divisor,
  output dtn_pkg::div_res_t             res
);
  import dtn_pkg::*;

  typedef enum logic [2:0] {
    STEP_RECIP = 3'b001,
    STEP_BACK  = 3'b010,
    STEP_FIX   = 3'b100
  } step_t;

  step_t                 step;
  logic                  busy;
  logic                  done;
  logic                  neg;
  logic                  scaled;
  logic [MicroShift-1:0] low;
  logic [31:0]           mag;
  logic [31:0]           recip;
  logic [DsrW-1:0]       dsr;
  logic [DsrW-1:0]       dsr_red;
  logic [QuoW-1:0]       quo;
  logic [32:0]           rem;
  logic [DsrW-1:0]       rem_full;

  logic [DivW-1:0]       abs_in;
  logic [31:0]           recip_sel;
  logic [DsrW-1:0]       red_sel;
  logic                  scaled_sel;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           prod;

  assign abs_in   = dividend[DivW-1] ? -dividend : dividend;
  assign mul_a    = (step == STEP_BACK) ? {{(32-QuoW){1'b0}}, quo} : mag;
  assign mul_b    = (step == STEP_BACK) ? {{(32-DsrW){1'b0}}, dsr_red} : recip;
  assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
  assign rem_full = scaled ? {rem[DsrW-MicroShift-1:0], low} : rem[DsrW-1:0];

  always_comb begin
    case (divisor)
      MicrosPerMin: begin
        recip_sel  = RecipMicros;
        red_sel    = MicrosRed;
        scaled_sel = 1'b1;
      end
      MinPerHour: begin
        recip_sel  = RecipMin;
        red_sel    = divisor;
        scaled_sel = 1'b0;
      end
      HourPerDay: begin
        recip_sel  = RecipHour;
        red_sel    = divisor;
        scaled_sel = 1'b0;
      end
      MonPerYear: begin
        recip_sel  = RecipMon;
        red_sel    = divisor;
        scaled_sel = 1'b0;
      end
      LeapCycle: begin
        recip_sel  = RecipCycle;
        red_sel    = divisor;
        scaled_sel = 1'b0;
      end
      default: begin
        recip_sel  = '0;
        red_sel    = divisor;
        scaled_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      done    <= 1'b0;
      step    <= STEP_RECIP;
      neg     <= dividend[DivW-1];
      scaled  <= scaled_sel;
      mag     <= scaled_sel ? abs_in[MicroShift +: 32] : abs_in[31:0];
      low     <= abs_in[MicroShift-1:0];
      recip   <= recip_sel;
      dsr     <= divisor;
      dsr_red <= red_sel;
      quo     <= '0;
      rem     <= '0;
    end else if (busy) begin
      case (step)
        STEP_RECIP: begin
          quo  <= prod[32 +: QuoW];
          step <= STEP_BACK;
        end
        STEP_BACK: begin
          rem  <= {1'b0, mag} - {1'b0, prod[31:0]};
          step <= STEP_FIX;
        end
        STEP_FIX: begin
          if (rem >= {{(33-DsrW){1'b0}}, dsr_red}) begin
            quo <= quo + QuoW'(1);
            rem <= rem - {{(33-DsrW){1'b0}}, dsr_red};
          end
          busy <= 1'b0;
          done <= 1'b1;
        end
        default: begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      endcase
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    res.done = done;
    if (neg && rem_full != '0) begin
      res.quo = -(QW'(quo) + QW'(1));
      res.rem = dsr - rem_full;
    end else if (neg) begin
      res.quo = -QW'(quo);
      res.rem = '0;
    end else begin
      res.quo = QW'(quo);
      res.rem = rem_full;
    end
  end

endmodule

// ===== rtl/date_time_normalizer.sv =====
// ----------------------------------------------------------------------------
// date_time_normalizer: Gregorian date and time normalization
// Brings out-of-range date and time fields into range with carries, using a
// shared floor divider, a year stepper and a month search.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   year_in .. micros_in
// out      output     out_valid/out_ready year_out .. micros_out
//
// One transaction takes five divider passes, one step of the year stepper per
// whole year stepped (up to about 200), and a month search over up to 12 months.
// The shared divider and the one-year-per-cycle stepper set the latency.
// Reset clears the sequencer, the divider control and out_valid.
// The result waits in output registers; a new transaction may be accepted
// while it waits, and the next result stalls only until it is taken.
module date_time_normalizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        year_in,
  input  logic signed [12:0] month_in,
  input  logic signed [16:0] day_in,
  input  logic signed [16:0] hour_in,
  input  logic signed [20:0] minute_in,
  input  logic signed [39:0] micros_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [8:0]         day_of_year,
  output logic [4:0]         hour_out,
  output logic [5:0]         minute_out,
  output logic [25:0]        micros_out
);
  import dtn_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_YEAR  = 5'b00100,
    ST_MSRCH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    PH_MONTH = 5'b00001,
    PH_YMOD  = 5'b00010,
    PH_SEC   = 5'b00100,
    PH_MIN   = 5'b01000,
    PH_HOUR  = 5'b10000
  } phase_t;

  state_t                   state;
  phase_t                   phase;
  logic                     div_start;
  logic signed [DivW-1:0]   dividend;
  logic [DsrW-1:0]          divisor;
  div_res_t                 dres;

  logic signed [12:0]       month_raw;
  logic [3:0]               mon;
  logic signed [16:0]       mday;
  logic signed [YearW-1:0]  year;
  logic [8:0]               ymod;
  logic signed [YdayW-1:0]  yday;
  logic signed [HourW-1:0]  hour;
  logic signed [MinW-1:0]   minute;
  logic signed [DivW-1:0]   micros;

  logic                     leap;
  logic [8:0]               ymod_dec;
  logic [8:0]               ndays;
  logic [8:0]               ndays_dec;
  logic [8:0]               ms_next;

  assign in_ready  = (state == ST_IDLE);
  assign leap      = leap_of(ymod);
  assign ymod_dec  = (ymod == 9'd0) ? 9'd399 : ymod - 9'd1;
  assign ndays     = leap ? 9'd366 : 9'd365;
  assign ndays_dec = leap_of(ymod_dec) ? 9'd366 : 9'd365;
  assign ms_next   = month_start(leap, mon + 4'd1);

  always_comb begin
    case (phase)
      PH_MONTH: begin
        dividend = {{(DivW-13){month_raw[12]}}, month_raw} - DivW'(1);
        divisor  = MonPerYear;
      end
      PH_YMOD: begin
        dividend = {{(DivW-YearW){year[YearW-1]}}, year};
        divisor  = LeapCycle;
      end
      PH_SEC: begin
        dividend = micros;
        divisor  = MicrosPerMin;
      end
      PH_MIN: begin
        dividend = {{(DivW-MinW){minute[MinW-1]}}, minute};
        divisor  = MinPerHour;
      end
      PH_HOUR: begin
        dividend = {{(DivW-HourW){hour[HourW-1]}}, hour};
        divisor  = HourPerDay;
      end
      default: begin
        dividend = '0;
        divisor  = MonPerYear;
      end
    endcase
  end

  dtn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_MONTH;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            month_raw <= month_in;
            mday      <= day_in;
            hour      <= {{(HourW-17){hour_in[16]}}, hour_in};
            minute    <= {{(MinW-21){minute_in[20]}}, minute_in};
            micros    <= {micros_in[39], micros_in};
            year      <= (year_in < 14'd100) ? YearW'(year_in) + CenturyBase
                                             : YearW'(year_in);
            phase     <= PH_MONTH;
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dres.done) begin
            case (phase)
              PH_MONTH: begin
                year      <= year + dres.quo[YearW-1:0];
                mon       <= dres.rem[3:0] + 4'd1;
                phase     <= PH_YMOD;
                div_start <= 1'b1;
              end
              PH_YMOD: begin
                ymod      <= dres.rem[8:0];
                yday      <= {{(YdayW-9){1'b0}}, month_start(leap_of(dres.rem[8:0]), mon)}
                             + {{(YdayW-17){mday[16]}}, mday};
                phase     <= PH_SEC;
                div_start <= 1'b1;
              end
              PH_SEC: begin
                minute    <= minute + {{(MinW-QW){dres.quo[QW-1]}}, dres.quo};
                micros    <= {{(DivW-DsrW){1'b0}}, dres.rem};
                phase     <= PH_MIN;
                div_start <= 1'b1;
              end
              PH_MIN: begin
                hour      <= hour + {{(HourW-QW){dres.quo[QW-1]}}, dres.quo};
                minute    <= dres.rem[MinW-1:0];
                phase     <= PH_HOUR;
                div_start <= 1'b1;
              end
              PH_HOUR: begin
                yday      <= yday + {{(YdayW-QW){dres.quo[QW-1]}}, dres.quo};
                hour      <= {{(HourW-5){1'b0}}, dres.rem[4:0]};
                state     <= ST_YEAR;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_YEAR: begin
          if (yday > $signed({{(YdayW-9){1'b0}}, ndays})) begin
            year <= year + YearW'(1);
            ymod <= (ymod == 9'd399) ? 9'd0 : ymod + 9'd1;
            yday <= yday - $signed({{(YdayW-9){1'b0}}, ndays});
          end else if (yday < $signed(YdayW'(1))) begin
            year <= year - YearW'(1);
            ymod <= ymod_dec;
            yday <= yday + $signed({{(YdayW-9){1'b0}}, ndays_dec});
          end else begin
            mon   <= 4'd1;
            state <= ST_MSRCH;
          end
        end
        ST_MSRCH: begin
          if (mon < 4'd12 && yday[8:0] > ms_next) begin
            mon <= mon + 4'd1;
          end else begin
            mday  <= {8'd0, yday[8:0] - month_start(leap, mon)};
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            year_out    <= year[14:0];
            month_out   <= mon;
            day_out     <= mday[4:0];
            day_of_year <= yday[8:0];
            hour_out    <= hour[4:0];
            minute_out  <= minute[5:0];
            micros_out  <= micros[25:0];
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/dtn_checker.sv =====
// ----------------------------------------------------------------------------
// dtn_checker: port-level checks for the date and time normalizer
// Watches the handshakes and the ranges of the normalized result.
// ----------------------------------------------------------------------------
module dtn_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         month_out,
  input logic [4:0]         hour_out,
  input logic [5:0]         minute_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before its transaction completed.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(month_out) && $stable(hour_out))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted again right after a transaction.");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_out >= 4'd1 && month_out <= 4'd12)
    else $error("Month out of range.");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour_out < 5'd24 && minute_out < 6'd60)
    else $error("Hour or minute out of range.");

endmodule

bind date_time_normalizer dtn_checker u_dtn_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .month_out  (month_out),
  .hour_out   (hour_out),
  .minute_out (minute_out)
);
